/* src/hsvrgb_pkg.sv */
package hsvrgb_pkg;

   localparam int HUE_WIDTH    = 9;
   localparam int PCT_WIDTH    = 7;
   localparam int LEVEL_WIDTH  = 8;
   localparam int SECTOR_WIDTH = 3;
   localparam int REM_WIDTH    = 6;
   localparam int KEEP_WIDTH   = 13;
   localparam int PROD_WIDTH   = PCT_WIDTH + KEEP_WIDTH;
   localparam int SUM_WIDTH    = 25;
   localparam int QUOT_WIDTH   = 18;
   localparam int RECIP_WIDTH  = 18;
   localparam int MULQ_WIDTH   = QUOT_WIDTH + RECIP_WIDTH;

   localparam logic [HUE_WIDTH-1:0]  HUE_FULL_TURN  = 9'd360;
   localparam logic [PCT_WIDTH-1:0]  PERCENT_MAX    = 7'd100;
   localparam logic [REM_WIDTH-1:0]  SECTOR_DEGREES = 6'd60;
   localparam logic [KEEP_WIDTH-1:0] FULL_KEEP      = 13'd6000;

   // 255/600000 reduces to 17/40000, and 40000 = 64 * 625. The quotient by 625
   // is a multiply by ceil(2^27/625) and a shift, exact for 18-bit operands.
   localparam logic [RECIP_WIDTH-1:0] RECIP_625   = 18'd214749;
   localparam int                     RECIP_SHIFT = 27;
   localparam int                     PRE_SHIFT   = 6;

   localparam logic [SECTOR_WIDTH-1:0] SECTOR_RED_YELLOW    = 3'd0;
   localparam logic [SECTOR_WIDTH-1:0] SECTOR_YELLOW_GREEN  = 3'd1;
   localparam logic [SECTOR_WIDTH-1:0] SECTOR_GREEN_CYAN    = 3'd2;
   localparam logic [SECTOR_WIDTH-1:0] SECTOR_CYAN_BLUE     = 3'd3;
   localparam logic [SECTOR_WIDTH-1:0] SECTOR_BLUE_MAGENTA  = 3'd4;
   localparam logic [SECTOR_WIDTH-1:0] SECTOR_MAGENTA_RED   = 3'd5;

   typedef struct packed {
      logic                    valid;
      logic [SECTOR_WIDTH-1:0] sector;
      logic [REM_WIDTH-1:0]    rem;
      logic [PCT_WIDTH-1:0]    sat;
      logic [PCT_WIDTH-1:0]    val;
   } sector_stage_type;

   typedef struct packed {
      logic                    valid;
      logic [SECTOR_WIDTH-1:0] sector;
   } pipe_tag_type;

endpackage

/* src/hsvrgb_sector.sv */
module hsvrgb_sector (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [hsvrgb_pkg::HUE_WIDTH-1:0]   hue,
   input  logic [hsvrgb_pkg::PCT_WIDTH-1:0]   saturation,
   input  logic [hsvrgb_pkg::PCT_WIDTH-1:0]   brightness,
   output hsvrgb_pkg::sector_stage_type       stage
);
   import hsvrgb_pkg::*;

   logic [HUE_WIDTH-1:0]    hue_wrap;
   logic [HUE_WIDTH-1:0]    sector_base;
   logic [HUE_WIDTH-1:0]    rem_full;
   sector_stage_type        stage_in;
   sector_stage_type        stage_ff;

   always_comb begin
      hue_wrap = (hue >= HUE_FULL_TURN) ? (hue - HUE_FULL_TURN) : hue;
      if (hue_wrap >= 9'd300) begin
         stage_in.sector = SECTOR_MAGENTA_RED;
         sector_base     = 9'd300;
      end else if (hue_wrap >= 9'd240) begin
         stage_in.sector = SECTOR_BLUE_MAGENTA;
         sector_base     = 9'd240;
      end else if (hue_wrap >= 9'd180) begin
         stage_in.sector = SECTOR_CYAN_BLUE;
         sector_base     = 9'd180;
      end else if (hue_wrap >= 9'd120) begin
         stage_in.sector = SECTOR_GREEN_CYAN;
         sector_base     = 9'd120;
      end else if (hue_wrap >= 9'd60) begin
         stage_in.sector = SECTOR_YELLOW_GREEN;
         sector_base     = 9'd60;
      end else begin
         stage_in.sector = SECTOR_RED_YELLOW;
         sector_base     = 9'd0;
      end
      rem_full       = hue_wrap - sector_base;
      stage_in.rem   = rem_full[REM_WIDTH-1:0];
      stage_in.sat   = (saturation > PERCENT_MAX) ? PERCENT_MAX : saturation;
      stage_in.val   = (brightness > PERCENT_MAX) ? PERCENT_MAX : brightness;
      stage_in.valid = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

/* src/hsvrgb_level.sv */
module hsvrgb_level (
   input  logic                                clock,
   input  logic [hsvrgb_pkg::PCT_WIDTH-1:0]    val,
   input  logic [hsvrgb_pkg::PCT_WIDTH-1:0]    sat,
   input  logic [hsvrgb_pkg::REM_WIDTH-1:0]    k,
   output logic [hsvrgb_pkg::LEVEL_WIDTH-1:0]  level
);
   import hsvrgb_pkg::*;

   logic [KEEP_WIDTH-1:0]  loss;
   logic [KEEP_WIDTH-1:0]  keep_in;
   logic [KEEP_WIDTH-1:0]  keep_ff;
   logic [PCT_WIDTH-1:0]   val_ff;
   logic [PROD_WIDTH-1:0]  prod_in;
   logic [PROD_WIDTH-1:0]  prod_ff;
   logic [SUM_WIDTH-1:0]   scaled;
   logic [QUOT_WIDTH-1:0]  quot_in;
   logic [QUOT_WIDTH-1:0]  quot_ff;
   logic [MULQ_WIDTH-1:0]  mulq;
   logic [LEVEL_WIDTH-1:0] level_in;
   logic [LEVEL_WIDTH-1:0] level_ff;

   // k never exceeds 60 and sat never exceeds 100, so the loss stays within 6000.
   always_comb begin
      loss     = KEEP_WIDTH'(k) * KEEP_WIDTH'(sat);
      keep_in  = FULL_KEEP - loss;
      prod_in  = PROD_WIDTH'(val_ff) * PROD_WIDTH'(keep_ff);
      scaled   = SUM_WIDTH'({prod_ff, 4'b0000}) + SUM_WIDTH'(prod_ff);
      quot_in  = scaled[PRE_SHIFT +: QUOT_WIDTH];
      mulq     = MULQ_WIDTH'(quot_ff) * MULQ_WIDTH'(RECIP_625);
      level_in = mulq[RECIP_SHIFT +: LEVEL_WIDTH];
   end

   always_ff @(posedge clock) begin
      keep_ff  <= keep_in;
      val_ff   <= val;
      prod_ff  <= prod_in;
      quot_ff  <= quot_in;
      level_ff <= level_in;
   end

   assign level = level_ff;

endmodule

/* src/hsv_to_rgb_converter_core.sv */
// HSV to RGB color converter, one color per item.
// Input: req_hue (degrees), req_saturation and req_brightness (percent) are
// taken at a rising clock edge where start is high and busy is low. Hue at
// 360 or above wraps once; saturation and brightness above 100 count as 100.
// Output: rsp_red, rsp_green and rsp_blue are shown for one cycle with
// rsp_strobe high, and are taken at the edge that ends that cycle.
// Path: an accepted item passes one sector stage, four stages of level
// arithmetic per channel (loss multiply, value multiply, scale by 17,
// reciprocal multiply by 1/625) and the output register.
// Throughput: one item per clock, sustained; busy is high only in reset.
// The receiver cannot stall, so nothing is ever held back.
// Reset clears every valid bit; items in flight are dropped and no strobe
// appears until a new item has run the full pipeline.
module hsv_to_rgb_converter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [hsvrgb_pkg::HUE_WIDTH-1:0]    req_hue,
   input  logic [hsvrgb_pkg::PCT_WIDTH-1:0]    req_saturation,
   input  logic [hsvrgb_pkg::PCT_WIDTH-1:0]    req_brightness,
   output logic                                rsp_strobe,
   output logic [hsvrgb_pkg::LEVEL_WIDTH-1:0]  rsp_red,
   output logic [hsvrgb_pkg::LEVEL_WIDTH-1:0]  rsp_green,
   output logic [hsvrgb_pkg::LEVEL_WIDTH-1:0]  rsp_blue
);
   import hsvrgb_pkg::*;

   localparam int LEVEL_STAGES = 4;

   sector_stage_type        s1;
   logic [REM_WIDTH-1:0]    k_rise;
   logic [LEVEL_WIDTH-1:0]  lv;
   logic [LEVEL_WIDTH-1:0]  lp;
   logic [LEVEL_WIDTH-1:0]  lq;
   logic [LEVEL_WIDTH-1:0]  lt;
   pipe_tag_type            tag_ff [LEVEL_STAGES];
   logic                    strobe_ff;
   logic [LEVEL_WIDTH-1:0]  red_in;
   logic [LEVEL_WIDTH-1:0]  green_in;
   logic [LEVEL_WIDTH-1:0]  blue_in;
   logic [LEVEL_WIDTH-1:0]  red_ff;
   logic [LEVEL_WIDTH-1:0]  green_ff;
   logic [LEVEL_WIDTH-1:0]  blue_ff;

   assign busy = reset;

   hsvrgb_sector u_sector (
      .clock      (clock),
      .reset      (reset),
      .accept     (start && !busy),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .stage      (s1)
   );

   assign k_rise = SECTOR_DEGREES - s1.rem;

   hsvrgb_level u_level_v (
      .clock (clock), .val (s1.val), .sat (s1.sat), .k (REM_WIDTH'(0)), .level (lv)
   );
   hsvrgb_level u_level_p (
      .clock (clock), .val (s1.val), .sat (s1.sat), .k (SECTOR_DEGREES), .level (lp)
   );
   hsvrgb_level u_level_q (
      .clock (clock), .val (s1.val), .sat (s1.sat), .k (s1.rem), .level (lq)
   );
   hsvrgb_level u_level_t (
      .clock (clock), .val (s1.val), .sat (s1.sat), .k (k_rise), .level (lt)
   );

   // The sector tag runs alongside the level units so it meets their results.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVEL_STAGES; i++) begin
            tag_ff[i].valid <= 1'b0;
         end
      end else begin
         tag_ff[0].valid <= s1.valid;
         for (int i = 1; i < LEVEL_STAGES; i++) begin
            tag_ff[i].valid <= tag_ff[i-1].valid;
         end
      end
      tag_ff[0].sector <= s1.sector;
      for (int i = 1; i < LEVEL_STAGES; i++) begin
         tag_ff[i].sector <= tag_ff[i-1].sector;
      end
   end

   always_comb begin
      case (tag_ff[LEVEL_STAGES-1].sector)
         SECTOR_RED_YELLOW: begin
            red_in = lv; green_in = lt; blue_in = lp;
         end
         SECTOR_YELLOW_GREEN: begin
            red_in = lq; green_in = lv; blue_in = lp;
         end
         SECTOR_GREEN_CYAN: begin
            red_in = lp; green_in = lv; blue_in = lt;
         end
         SECTOR_CYAN_BLUE: begin
            red_in = lp; green_in = lq; blue_in = lv;
         end
         SECTOR_BLUE_MAGENTA: begin
            red_in = lt; green_in = lp; blue_in = lv;
         end
         default: begin
            red_in = lv; green_in = lp; blue_in = lq;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tag_ff[LEVEL_STAGES-1].valid;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_red    = red_ff;
   assign rsp_green  = green_ff;
   assign rsp_blue   = blue_ff;

   a_strobe_from_accept : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 6))
      else $error("result strobe without an accepted item six cycles earlier");

   a_sector_stage_range : assert property (@(posedge clock) disable iff (reset)
      s1.valid |-> (s1.rem < SECTOR_DEGREES) && (s1.sat <= PERCENT_MAX)
                   && (s1.val <= PERCENT_MAX) && (s1.sector <= SECTOR_MAGENTA_RED))
      else $error("sector stage holds an out of range item");

   a_gray_when_unsaturated : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_saturation == 7'd0, 6))
      |-> (rsp_red == rsp_green) && (rsp_green == rsp_blue))
      else $error("zero saturation item did not give a gray result");

   a_black_when_dark : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_brightness == 7'd0, 6))
      |-> (rsp_red == 8'd0) && (rsp_green == 8'd0) && (rsp_blue == 8'd0))
      else $error("zero brightness item did not give black");

endmodule
